/* rtl/core/gnfs_pkg.sv */
// Shared types and constants of the nearest / farthest grid cell selector.
// No dependencies; every other file of the block imports this package.
package gnfs_pkg;

  // Default width of a linear cell index
  localparam int unsigned IndexBitsDef = 20;

  // Fixed register field widths
  localparam int unsigned GwW      = 13;
  localparam int unsigned RobotW   = 20;
  localparam int unsigned MinDistW = 12;
  localparam int unsigned MinSqW   = 2 * MinDistW;

  // Register reset values
  localparam logic [GwW-1:0]      GwReset      = 13'd1;
  localparam logic [RobotW-1:0]   RobotReset   = 20'd0;
  localparam logic [MinDistW-1:0] MinDistReset = 12'd25;

  // Register map: word index on paddr[3:2]
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;
  localparam logic [1:0] RegGridWidth   = 2'd0;
  localparam logic [1:0] RegRobotCell   = 2'd1;
  localparam logic [1:0] RegMinDistance = 2'd2;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_DIFF,
    BK_SQ,
    BK_UPD
  } back_state_e;

  // Configuration handed to the back end
  typedef struct packed {
    logic [GwW-1:0]      grid_width;
    logic [RobotW-1:0]   robot_cell;
    logic [MinDistW-1:0] min_distance;
  } cfg_t;

endpackage

/* rtl/core/gnfs_front.sv */
// Front end: accepts cell words and holds them in a short queue for the back end.
// Depends on gnfs_pkg for the queue depth.
module gnfs_front
  import gnfs_pkg::*;
#(
  parameter int unsigned IndexBits = IndexBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IndexBits-1:0] cell_index_i,
  input  logic                 last_item_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output logic [IndexBits-1:0] q_cell_o,
  output logic                 q_last_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [IndexBits-1:0] cell_mem [QueueDepth];
  logic                 last_mem [QueueDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 push, pop;

  // Queue status
  assign in_ready_o = (cnt_q != CntW'(QueueDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_valid_o & q_ready_i;
  assign q_cell_o   = cell_mem[rd_ptr_q];
  assign q_last_o   = last_mem[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push) begin
      cell_mem[wr_ptr_q] <= cell_index_i;
      last_mem[wr_ptr_q] <= last_item_i;
    end
  end

endmodule

/* rtl/core/gnfs_div.sv */
// Restoring divider: one quotient bit per cycle, index by grid width.
// Depends on gnfs_pkg for the divisor width.
module gnfs_div
  import gnfs_pkg::*;
#(
  parameter int unsigned IndexBits = IndexBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [IndexBits-1:0] dividend_i,
  input  logic [GwW-1:0]       divisor_i,
  output logic                 busy_o,
  output logic [IndexBits-1:0] quot_o,
  output logic [GwW-1:0]       rem_o
);

  localparam int unsigned CntW = $clog2(IndexBits + 1);

  logic                 busy_q;
  logic [CntW-1:0]      cnt_q;
  logic [IndexBits-1:0] quot_q;
  logic [GwW-1:0]       rem_q, rem_d;
  logic [GwW-1:0]       div_q;
  logic [GwW:0]         partial;
  logic                 q_bit;

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  // One trial subtraction
  always_comb begin
    partial = {rem_q, quot_q[IndexBits-1]};
    if (partial >= {1'b0, div_q}) begin
      q_bit = 1'b1;
      rem_d = GwW'(partial - {1'b0, div_q});
    end else begin
      q_bit = 1'b0;
      rem_d = partial[GwW-1:0];
    end
  end

  // Count down the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(IndexBits);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Shift dividend out and quotient in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[IndexBits-2:0], q_bit};
      rem_q  <= rem_d;
    end
  end

endmodule

/* rtl/core/gnfs_back.sv */
// Back end: splits cell and robot index, forms squared distance, keeps both winners.
// Depends on gnfs_pkg and instantiates two gnfs_div units.
module gnfs_back
  import gnfs_pkg::*;
#(
  parameter int unsigned IndexBits = IndexBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  logic [IndexBits-1:0] q_cell_i,
  input  logic                 q_last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IndexBits-1:0] nearest_cell_o,
  output logic [IndexBits-1:0] farthest_cell_o,
  output logic                 nearest_found_o
);

  localparam int unsigned SqW = ((2 * IndexBits > 2 * GwW) ? 2 * IndexBits : 2 * GwW) + 1;

  back_state_e state_q, state_d;

  logic                   pop, can_go, do_upd;
  logic [GwW-1:0]         gw_eff;
  logic                   cell_busy, robot_busy;
  logic [IndexBits-1:0]   cell_row, robot_row;
  logic [GwW-1:0]         cell_col, robot_col;

  logic [IndexBits-1:0]   cell_q;
  logic                   last_q;
  logic [IndexBits-1:0]   dr_q;
  logic [GwW-1:0]         dc_q;
  logic [2*IndexBits-1:0] dr_sq_q;
  logic [2*GwW-1:0]       dc_sq_q;
  logic [MinSqW-1:0]      min_sq_q;

  logic [SqW-1:0]         near_sq_q, far_sq_q;
  logic [IndexBits-1:0]   near_cell_q, far_cell_q, first_cell_q;
  logic                   near_valid_q, started_q;

  logic [SqW-1:0]         sq;
  logic                   near_hit, far_hit;
  logic [SqW-1:0]         near_sq_n, far_sq_n;
  logic [IndexBits-1:0]   near_cell_n, far_cell_n, first_cell_n;
  logic                   near_valid_n;

  logic                   out_valid_q;
  logic [IndexBits-1:0]   out_near_q, out_far_q;
  logic                   out_found_q;

  assign q_ready_o = (state_q == BK_IDLE);
  assign pop       = q_valid_i & q_ready_o;
  assign gw_eff    = (cfg_i.grid_width == '0) ? GwW'(1) : cfg_i.grid_width;

  // Split cell and robot index into row and column
  gnfs_div #(.IndexBits(IndexBits)) u_div_cell (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (pop),
    .dividend_i (q_cell_i),
    .divisor_i  (gw_eff),
    .busy_o     (cell_busy),
    .quot_o     (cell_row),
    .rem_o      (cell_col)
  );

  gnfs_div #(.IndexBits(IndexBits)) u_div_robot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (pop),
    .dividend_i (IndexBits'(cfg_i.robot_cell)),
    .divisor_i  (gw_eff),
    .busy_o     (robot_busy),
    .quot_o     (robot_row),
    .rem_o      (robot_col)
  );

  // Hold the final update while the previous result is still waiting
  assign can_go = !last_q || !out_valid_q || out_ready_i;
  assign do_upd = (state_q == BK_UPD) && can_go;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (pop) state_d = BK_DIV;
      BK_DIV:  if (!cell_busy && !robot_busy) state_d = BK_DIFF;
      BK_DIFF: state_d = BK_SQ;
      BK_SQ:   state_d = BK_UPD;
      BK_UPD:  if (can_go) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Distance datapath: latch item, absolute differences, squares
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cell_q <= q_cell_i;
      last_q <= q_last_i;
    end
    if (state_q == BK_DIFF) begin
      dr_q <= (robot_row >= cell_row) ? robot_row - cell_row : cell_row - robot_row;
      dc_q <= (robot_col >= cell_col) ? robot_col - cell_col : cell_col - robot_col;
    end
    if (state_q == BK_SQ) begin
      dr_sq_q  <= (2 * IndexBits)'(dr_q) * (2 * IndexBits)'(dr_q);
      dc_sq_q  <= (2 * GwW)'(dc_q) * (2 * GwW)'(dc_q);
      min_sq_q <= MinSqW'(cfg_i.min_distance) * MinSqW'(cfg_i.min_distance);
    end
  end

  // Compare against both winners; the first item seeds the fallback cells
  always_comb begin
    sq           = SqW'(dr_sq_q) + SqW'(dc_sq_q);
    first_cell_n = started_q ? first_cell_q : cell_q;
    near_cell_n  = started_q ? near_cell_q : cell_q;
    far_cell_n   = started_q ? far_cell_q : cell_q;
    near_sq_n    = near_sq_q;
    far_sq_n     = far_sq_q;
    near_valid_n = near_valid_q;
    near_hit     = (sq > SqW'(min_sq_q)) && (!near_valid_q || (sq < near_sq_q));
    far_hit      = (sq > far_sq_q);
    if (near_hit) begin
      near_sq_n    = sq;
      near_cell_n  = cell_q;
      near_valid_n = 1'b1;
    end
    if (far_hit) begin
      far_sq_n   = sq;
      far_cell_n = cell_q;
    end
  end

  // Winner state: keep on ordinary items, clear after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_sq_q    <= '1;
      far_sq_q     <= '0;
      near_cell_q  <= '0;
      far_cell_q   <= '0;
      first_cell_q <= '0;
      near_valid_q <= 1'b0;
      started_q    <= 1'b0;
    end else if (do_upd) begin
      if (last_q) begin
        near_sq_q    <= '1;
        far_sq_q     <= '0;
        near_cell_q  <= '0;
        far_cell_q   <= '0;
        first_cell_q <= '0;
        near_valid_q <= 1'b0;
        started_q    <= 1'b0;
      end else begin
        near_sq_q    <= near_sq_n;
        far_sq_q     <= far_sq_n;
        near_cell_q  <= near_cell_n;
        far_cell_q   <= far_cell_n;
        first_cell_q <= first_cell_n;
        near_valid_q <= near_valid_n;
        started_q    <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_upd && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_upd && last_q) begin
      out_near_q  <= near_valid_n ? near_cell_n : first_cell_n;
      out_far_q   <= far_cell_n;
      out_found_q <= near_valid_n;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign nearest_cell_o  = out_near_q;
  assign farthest_cell_o = out_far_q;
  assign nearest_found_o = out_found_q;

endmodule

/* rtl/core/grid_nearest_farthest_select.sv */
// Nearest / farthest grid cell selector. Cells arrive as linear indices, each list closed by
// last_item_i; the block reports the nearest cell lying strictly beyond min_distance and the
// farthest cell from robot_cell, ties going to the earlier cell, with the list's first cell as
// fallback. The back end handles one item at a time: it takes the word from the queue, runs a
// restoring divider that yields one quotient bit per cycle for the row/column split, sees the
// divider finish, then forms the differences and squares and makes the winner update. The last
// word of a list waits in the update step for as long as the previous result is still held. A
// two-word queue lets the input side run ahead and a result register lets the next list start
// while a result waits.
// Registers (APB, 32-bit words): 0x0 grid_width (0 acts as 1), 0x4 robot_cell, 0x8 min_distance.
// Depends on gnfs_pkg, gnfs_front, gnfs_div and gnfs_back.
module grid_nearest_farthest_select
  import gnfs_pkg::*;
#(
  parameter int unsigned IndexBits = IndexBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ApbAddrW-1:0]  paddr,
  input  logic [ApbDataW-1:0]  pwdata,
  output logic [ApbDataW-1:0]  prdata,
  output logic                 pready,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IndexBits-1:0] cell_index_i,
  input  logic                 last_item_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IndexBits-1:0] nearest_cell_o,
  output logic [IndexBits-1:0] farthest_cell_o,
  output logic                 nearest_found_o
);

  logic [GwW-1:0]       grid_width_q;
  logic [RobotW-1:0]    robot_cell_q;
  logic [MinDistW-1:0]  min_distance_q;
  logic                 cfg_wr;
  logic [1:0]           reg_idx;
  cfg_t                 cfg;

  logic                 q_valid, q_ready, q_last;
  logic [IndexBits-1:0] q_cell;

  // Register write and read
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q   <= GwReset;
      robot_cell_q   <= RobotReset;
      min_distance_q <= MinDistReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegGridWidth:   grid_width_q   <= pwdata[GwW-1:0];
        RegRobotCell:   robot_cell_q   <= pwdata[RobotW-1:0];
        RegMinDistance: min_distance_q <= pwdata[MinDistW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegGridWidth:   prdata = ApbDataW'(grid_width_q);
      RegRobotCell:   prdata = ApbDataW'(robot_cell_q);
      RegMinDistance: prdata = ApbDataW'(min_distance_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg.grid_width   = grid_width_q;
  assign cfg.robot_cell   = robot_cell_q;
  assign cfg.min_distance = min_distance_q;

  gnfs_front #(.IndexBits(IndexBits)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cell_index_i (cell_index_i),
    .last_item_i  (last_item_i),
    .q_valid_o    (q_valid),
    .q_ready_i    (q_ready),
    .q_cell_o     (q_cell),
    .q_last_o     (q_last)
  );

  gnfs_back #(.IndexBits(IndexBits)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .q_valid_i       (q_valid),
    .q_ready_o       (q_ready),
    .q_cell_i        (q_cell),
    .q_last_i        (q_last),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .nearest_cell_o  (nearest_cell_o),
    .farthest_cell_o (farthest_cell_o),
    .nearest_found_o (nearest_found_o)
  );

`ifndef SYNTHESIS
  // A full queue always has a word to offer
  a_full_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("queue full but empty to the back end");

  // An accepted word is in the queue at the next edge
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> q_valid)
    else $error("accepted word missing from queue");

  // The back end takes one word at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready) |=> !q_ready)
    else $error("back end took a second word while busy");
`endif

endmodule
